[rtl/mfc_pkg.sv]
package mfc_pkg;

    // Sizes and limits
    localparam int unsigned QUEUE_DEPTH_DEF = 4;
    localparam int unsigned STEP_W          = 5;
    localparam logic [9:0]  MAX_PAYLOAD     = 10'd997;
    localparam logic [9:0]  HEADER_END      = 10'd26;
    localparam logic [9:0]  HEADER_START    = 10'd2;
    localparam logic [STEP_W-1:0] HDR_LAST  = STEP_W'(23);
    localparam logic [STEP_W-1:0] HDR_CHK_HI = STEP_W'(24);

    // Frame offsets of the checksum bytes
    localparam logic [9:0]  CHK_HI_OFFSET   = 10'd0;
    localparam logic [9:0]  CHK_LO_OFFSET   = 10'd1;

    // Register reset values
    localparam logic [31:0] SENDER_NODE_RST   = 32'd1;
    localparam logic [31:0] SENDER_THREAD_RST = 32'd1;
    localparam logic [15:0] HOP_LIMIT_RST     = 16'd10;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_SENDER_NODE   = 2'd0;
    localparam logic [1:0] CFG_SENDER_THREAD = 2'd1;
    localparam logic [1:0] CFG_HOP_LIMIT     = 2'd2;

    // Input command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_DATA  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ORPHAN  = 2'd1;
    localparam logic [1:0] ST_ABANDON = 2'd2;

    typedef enum logic [1:0] {
        JOB_START  = 2'd0,
        JOB_DATA   = 2'd1,
        JOB_ORPHAN = 2'd2
    } job_kind_t;

    typedef struct packed {
        logic        command;
        logic [31:0] topic_id;
        logic [63:0] timestamp_ns;
        logic [9:0]  data_length;
        logic [7:0]  data_byte;
    } in_t;

    typedef struct packed {
        logic [9:0] frame_offset;
        logic [7:0] frame_byte;
        logic       frame_done;
        logic [1:0] status;
    } out_t;

    typedef struct packed {
        logic [31:0] sender_node;
        logic [31:0] sender_thread;
        logic [15:0] hop_limit;
    } cfg_t;

    // One classified work unit handed from front to back
    typedef struct packed {
        job_kind_t   kind;
        logic [1:0]  status;
        logic        last;          // frame closes after this job
        logic [31:0] topic_id;
        logic [63:0] timestamp_ns;
        logic [9:0]  length;        // clamped payload length
        logic [9:0]  offset;        // frame offset of a data byte
        logic [7:0]  data_byte;
    } job_t;

    // Rotate right by one, then add the byte modulo 2^16
    function automatic logic [15:0] fold(input logic [15:0] sum, input logic [7:0] b);
        fold = {sum[0], sum[15:1]} + {8'd0, b};
    endfunction

endpackage

[rtl/mfc_front.sv]
module mfc_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  mfc_pkg::in_t  in_data,
    input  logic          q_full,
    output logic          push,
    output mfc_pkg::job_t job
);
    import mfc_pkg::*;

    logic       frame_open_reg, frame_open_next;
    logic [9:0] bytes_left_reg, bytes_left_next;
    logic [9:0] next_offset_reg, next_offset_next;
    logic [9:0] len_clamped;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    assign len_clamped = (in_data.data_length > MAX_PAYLOAD) ? MAX_PAYLOAD
                                                             : in_data.data_length;

    // Classify the beat and track frame state
    always_comb
    begin
        job.kind         = JOB_ORPHAN;
        job.status       = ST_ORPHAN;
        job.last         = 1'b1;
        job.topic_id     = in_data.topic_id;
        job.timestamp_ns = in_data.timestamp_ns;
        job.length       = len_clamped;
        job.offset       = next_offset_reg;
        job.data_byte    = in_data.data_byte;

        frame_open_next  = frame_open_reg;
        bytes_left_next  = bytes_left_reg;
        next_offset_next = next_offset_reg;

        if (in_data.command == CMD_START)
        begin
            job.kind         = JOB_START;
            job.status       = frame_open_reg ? ST_ABANDON : ST_OK;
            job.last         = (len_clamped == 10'd0);
            job.offset       = HEADER_END;
            frame_open_next  = (len_clamped != 10'd0);
            bytes_left_next  = len_clamped;
            next_offset_next = HEADER_END;
        end
        else if (frame_open_reg)
        begin
            job.kind         = JOB_DATA;
            job.status       = ST_OK;
            job.last         = (bytes_left_reg == 10'd1);
            frame_open_next  = (bytes_left_reg != 10'd1);
            bytes_left_next  = bytes_left_reg - 10'd1;
            next_offset_next = next_offset_reg + 10'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg  <= 1'b0;
            bytes_left_reg  <= 10'd0;
            next_offset_reg <= 10'd0;
        end
        else if (push)
        begin
            frame_open_reg  <= frame_open_next;
            bytes_left_reg  <= bytes_left_next;
            next_offset_reg <= next_offset_next;
        end
    end

endmodule

[rtl/mfc_queue.sv]
module mfc_queue #(
    parameter int unsigned DEPTH = mfc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mfc_pkg::job_t job_in,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output mfc_pkg::job_t job_out
);
    import mfc_pkg::*;

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign valid   = (count_reg != '0);
    assign job_out = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= job_in;
    end

endmodule

[rtl/mfc_back.sv]
module mfc_back (
    input  logic          clk,
    input  logic          rst_n,
    input  mfc_pkg::cfg_t cfg,
    input  logic          q_valid,
    input  mfc_pkg::job_t job,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_stall,
    output mfc_pkg::out_t out_data
);
    import mfc_pkg::*;

    logic [STEP_W-1:0] step_reg;
    logic [15:0]       sum_reg;
    logic              out_valid_reg;
    out_t              out_reg;

    logic [191:0]      hdr_vec;
    logic [STEP_W-1:0] hdr_sel;
    logic [7:0]        hdr_byte;
    out_t              res;
    logic              fold_en;
    logic [15:0]       fold_base;
    logic              last_step;
    logic              advance;

    // Header bytes, big-endian, offsets 2 to 25
    assign hdr_vec  = {cfg.sender_node, job.timestamp_ns, cfg.sender_thread,
                       job.topic_id, cfg.hop_limit, 6'd0, job.length};
    assign hdr_sel  = HDR_LAST - step_reg;
    assign hdr_byte = hdr_vec[{hdr_sel, 3'b000} +: 8];

    // Result of the current step of the head job
    always_comb
    begin
        res.frame_offset = CHK_HI_OFFSET;
        res.frame_byte   = 8'd0;
        res.frame_done   = 1'b0;
        res.status       = job.status;
        fold_en          = 1'b0;
        fold_base        = sum_reg;
        last_step        = 1'b0;

        unique case (job.kind)
            JOB_START:
            begin
                if (step_reg <= HDR_LAST)
                begin
                    res.frame_offset = {{(10-STEP_W){1'b0}}, step_reg} + HEADER_START;
                    res.frame_byte   = hdr_byte;
                    fold_en          = 1'b1;
                    fold_base        = (step_reg == '0) ? 16'd0 : sum_reg;
                    last_step        = (step_reg == HDR_LAST) && !job.last;
                end
                else if (step_reg == HDR_CHK_HI)
                begin
                    res.frame_byte   = sum_reg[15:8];
                end
                else
                begin
                    res.frame_offset = CHK_LO_OFFSET;
                    res.frame_byte   = sum_reg[7:0];
                    res.frame_done   = 1'b1;
                    last_step        = 1'b1;
                end
            end
            JOB_DATA:
            begin
                if (step_reg == '0)
                begin
                    res.frame_offset = job.offset;
                    res.frame_byte   = job.data_byte;
                    fold_en          = 1'b1;
                    last_step        = !job.last;
                end
                else if (step_reg == STEP_W'(1))
                begin
                    res.frame_byte   = sum_reg[15:8];
                end
                else
                begin
                    res.frame_offset = CHK_LO_OFFSET;
                    res.frame_byte   = sum_reg[7:0];
                    res.frame_done   = 1'b1;
                    last_step        = 1'b1;
                end
            end
            JOB_ORPHAN:
            begin
                last_step = 1'b1;
            end
            default:
            begin
                last_step = 1'b1;
            end
        endcase
    end

    assign advance   = q_valid && (!out_valid_reg || !out_stall);
    assign pop       = advance && last_step;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Step counter, checksum and output beat control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            sum_reg       <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
            step_reg      <= last_step ? '0 : step_reg + STEP_W'(1);
            if (fold_en)
                sum_reg <= fold(fold_base, res.frame_byte);
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= res;
    end

endmodule

[rtl/message_framer_with_rotating_checksum.sv]
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_stall  | in_data (command, topic, stamp, length, byte)
// out     | output    | out_valid / out_stall| out_data (offset, byte, done, status)
// cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A data beat inside a frame yields one result, the last one three (byte
// plus two checksum bytes); a start yields 24 header bytes, or 26 with an
// empty payload; a stray data beat yields one. Results leave one byte per cycle
// from a single output register while a job waits and out_stall is low.
// The job queue lets the input side keep taking beats while a header drains.
// Reset clears frame state, the checksum, the queue and all valids; the
// registers return to node 1, thread 1, hop limit 10. cfg_ready is always high.
module message_framer_with_rotating_checksum #(
    parameter int unsigned QUEUE_DEPTH = mfc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  mfc_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output mfc_pkg::out_t out_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data
);
    import mfc_pkg::*;

    cfg_t cfg_reg;
    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    job_t job_in;
    job_t job_head;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sender_node   <= SENDER_NODE_RST;
            cfg_reg.sender_thread <= SENDER_THREAD_RST;
            cfg_reg.hop_limit     <= HOP_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SENDER_NODE:   cfg_reg.sender_node   <= cfg_data;
                CFG_SENDER_THREAD: cfg_reg.sender_thread <= cfg_data;
                CFG_HOP_LIMIT:     cfg_reg.hop_limit     <= cfg_data[15:0];
                default:           ;
            endcase
        end
    end

    // Front: accept and classify
    mfc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_full   (q_full),
        .push     (push),
        .job      (job_in)
    );

    // Job queue between the two sides
    mfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .job_in  (job_in),
        .full    (q_full),
        .pop     (pop),
        .valid   (q_valid),
        .job_out (job_head)
    );

    // Back: emit bytes and run the checksum
    mfc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .job       (job_head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

[bench/tb_message_framer_with_rotating_checksum.sv]
`timescale 1ns / 1ps

module tb_message_framer_with_rotating_checksum;
    import mfc_pkg::*;

    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 310;
    localparam int PHASE_ITEMS  = 75;

    // Tracks frame state and config, predicts every frame byte
    class frame_byte_tracker;
        logic [31:0] node_id;
        logic [31:0] thread_id;
        logic [15:0] hop_limit;
        logic [15:0] check_sum;
        logic [9:0]  bytes_left;
        logic [9:0]  next_offset;
        bit          frame_open;
        out_t        pending_bytes[$];
        int          errors;

        function new();
            node_id     = SENDER_NODE_RST;
            thread_id   = SENDER_THREAD_RST;
            hop_limit   = HOP_LIMIT_RST;
            check_sum   = '0;
            bytes_left  = '0;
            next_offset = '0;
            frame_open  = 1'b0;
            errors      = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] value);
            case (idx)
                CFG_SENDER_NODE:   node_id   = value;
                CFG_SENDER_THREAD: thread_id = value;
                CFG_HOP_LIMIT:     hop_limit = value[15:0];
                default: ;
            endcase
        endfunction

        // Rotate right by one, then add the byte
        function logic [15:0] rotate_add(logic [15:0] s, logic [7:0] b);
            return {s[0], s[15:1]} + {8'd0, b};
        endfunction

        function void queue_byte(logic [9:0] off, logic [7:0] value, logic done,
                                 logic [1:0] st);
            out_t r;
            r.frame_offset = off;
            r.frame_byte   = value;
            r.frame_done   = done;
            r.status       = st;
            pending_bytes.push_back(r);
        endfunction

        // Checksum goes out high byte first, then the frame closes
        function void close_frame(logic [1:0] st);
            queue_byte(CHK_HI_OFFSET, check_sum[15:8], 1'b0, st);
            queue_byte(CHK_LO_OFFSET, check_sum[7:0], 1'b1, st);
            frame_open = 1'b0;
            bytes_left = '0;
        endfunction

        function void take_beat(in_t beat);
            logic [191:0] hdr;
            logic [9:0]   len;
            logic [1:0]   st;
            if (beat.command == CMD_START)
            begin
                st  = frame_open ? ST_ABANDON : ST_OK;
                len = (beat.data_length > MAX_PAYLOAD) ? MAX_PAYLOAD : beat.data_length;
                hdr = {node_id, beat.timestamp_ns, thread_id, beat.topic_id,
                       hop_limit, 6'd0, len};
                check_sum = '0;
                for (int i = 0; i < 24; i++)
                begin
                    check_sum = rotate_add(check_sum, hdr[191 - 8*i -: 8]);
                    queue_byte(HEADER_START + 10'(i), hdr[191 - 8*i -: 8], 1'b0, st);
                end
                frame_open  = 1'b1;
                next_offset = HEADER_END;
                bytes_left  = len;
                if (len == '0)
                    close_frame(st);
            end
            else if (!frame_open)
            begin
                queue_byte('0, '0, 1'b0, ST_ORPHAN);
            end
            else
            begin
                check_sum = rotate_add(check_sum, beat.data_byte);
                queue_byte(next_offset, beat.data_byte, 1'b0, ST_OK);
                next_offset = next_offset + 10'd1;
                bytes_left  = bytes_left - 10'd1;
                if (bytes_left == '0)
                    close_frame(ST_OK);
            end
        endfunction

        function void match_byte(out_t got);
            out_t want;
            if (pending_bytes.size() == 0)
            begin
                $error("unexpected beat: frame_offset %0d frame_byte %h",
                       got.frame_offset, got.frame_byte);
                errors++;
                return;
            end
            want = pending_bytes.pop_front();
            if (got.frame_offset !== want.frame_offset)
            begin
                $error("frame_offset: expected %0d, actual %0d",
                       want.frame_offset, got.frame_offset);
                errors++;
            end
            if (got.frame_byte !== want.frame_byte)
            begin
                $error("frame_byte: expected %h, actual %h", want.frame_byte, got.frame_byte);
                errors++;
            end
            if (got.frame_done !== want.frame_done)
            begin
                $error("frame_done: expected %b, actual %b", want.frame_done, got.frame_done);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_t         in_data;
    logic        out_valid;
    logic        out_stall;
    out_t        out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    frame_byte_tracker tracker;
    bit calm;
    bit hold_req;
    int hold_left;

    message_framer_with_rotating_checksum i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // Receiver: random stalls, or a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (calm)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 11);
    end

    // Monitor: config writes, accepted inputs, accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                tracker.set_reg(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                tracker.take_beat(in_data);
            if (out_valid && !out_stall)
                tracker.match_byte(out_data);
        end
    end

    function automatic in_t make_start(logic [31:0] topic, logic [63:0] stamp,
                                       logic [9:0] len);
        in_t b;
        b.command      = CMD_START;
        b.topic_id     = topic;
        b.timestamp_ns = stamp;
        b.data_length  = len;
        b.data_byte    = 8'($urandom);
        return b;
    endfunction

    // Unused fields of a data beat carry random junk
    function automatic in_t make_data(logic [7:0] value);
        in_t b;
        b.command      = CMD_DATA;
        b.topic_id     = $urandom;
        b.timestamp_ns = {$urandom, $urandom};
        b.data_length  = 10'($urandom);
        b.data_byte    = value;
        return b;
    endfunction

    function automatic logic [31:0] pick_reg_value();
        case ($urandom_range(2))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // One input beat, with an occasional gap ahead of it
    task automatic send_item(in_t beat);
        @(negedge clk);
        if (!calm && $urandom_range(99) < 11)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Stop offering beats until every predicted byte is back
    task automatic wait_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        do @(posedge clk); while (tracker.pending_bytes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_frame(logic [9:0] len);
        send_item(make_start($urandom, {$urandom, $urandom}, len));
        for (int i = 0; i < len; i++)
            send_item(make_data(8'($urandom)));
    endtask

    initial
    begin
        int         sent;
        int         next_phase;
        int         pick;
        int         hi;
        logic [9:0] len;
        logic [9:0] eff;

        tracker   = new();
        clk       = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        calm      = 1'b0;
        hold_req  = 1'b0;
        hold_left = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, reset config: stray byte, empty payload, short frame
        send_item(make_data(8'hFF));
        send_item(make_start(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 10'd0));
        send_item(make_start(32'h0, 64'h0, 10'd3));
        send_item(make_data(8'h00));
        send_item(make_data(8'hFF));
        send_item(make_data(8'h5A));
        send_item(make_data(8'h00));
        wait_drain();

        write_reg(CFG_SENDER_NODE, 32'hFFFF_FFFF);
        write_reg(CFG_SENDER_THREAD, 32'h0);
        write_reg(CFG_HOP_LIMIT, 32'h0000_FFFF);

        // Directed: clamped lengths, abandoned frames, last-byte close
        send_item(make_start(32'hA5A5_5A5A, 64'h0123_4567_89AB_CDEF, 10'd1023));
        send_item(make_data(8'h81));
        send_item(make_data(8'h7E));
        send_item(make_start(32'h5A5A_A5A5, 64'hFEDC_BA98_7654_3210, 10'd998));
        send_item(make_start(32'h1, 64'h1, MAX_PAYLOAD));
        send_item(make_data(8'h01));
        send_item(make_start(32'h8000_0000, 64'h8000_0000_0000_0000, 10'd0));
        send_item(make_start(32'h1234_5678, 64'h0, 10'd2));
        send_item(make_data(8'h80));
        send_item(make_start(32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 10'd1));
        send_item(make_data(8'h7F));
        send_item(make_data(8'h33));
        wait_drain();

        write_reg(CFG_SENDER_NODE, 32'h0);
        write_reg(CFG_SENDER_THREAD, 32'hFFFF_FFFF);
        write_reg(CFG_HOP_LIMIT, 32'h0);

        // One long frame with no idling on either side
        calm = 1'b1;
        send_frame(10'd60);
        wait_drain();
        calm = 1'b0;

        // Receiver holds off while the sender keeps pushing
        hold_req = 1'b1;
        send_frame(10'd50);
        send_frame(10'd0);
        wait_drain();

        // Random frames in phases, config rewritten between phases
        sent       = 0;
        next_phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= next_phase)
            begin
                wait_drain();
                write_reg(CFG_SENDER_NODE, pick_reg_value());
                write_reg(CFG_SENDER_THREAD, pick_reg_value());
                write_reg(CFG_HOP_LIMIT, pick_reg_value());
                calm       = (next_phase == 2 * PHASE_ITEMS);
                next_phase = next_phase + PHASE_ITEMS;
            end
            pick = $urandom_range(99);
            if (pick < 8)
            begin
                // frame is always closed here, so this byte is stray
                send_item(make_data(8'($urandom)));
                sent++;
            end
            else
            begin
                if (pick < 22)
                begin
                    // start with any length, cut short by the next start
                    len = 10'($urandom);
                    eff = (len > MAX_PAYLOAD) ? MAX_PAYLOAD : len;
                    hi  = (eff == 0) ? 0 : ((eff > 9) ? 8 : eff - 1);
                    send_item(make_start($urandom, {$urandom, $urandom}, len));
                    sent++;
                    for (int i = $urandom_range(hi); i > 0; i--)
                    begin
                        send_item(make_data(8'($urandom)));
                        sent++;
                    end
                end
                pick = $urandom_range(99);
                if (pick < 15)
                    len = 10'd0;
                else if (pick < 80)
                    len = 10'($urandom_range(1, 8));
                else
                    len = 10'($urandom_range(9, 40));
                send_frame(len);
                sent = sent + 1 + len;
            end
        end
        wait_drain();

        if (tracker.pending_bytes.size() != 0)
        begin
            $error("%0d predicted bytes never arrived", tracker.pending_bytes.size());
            tracker.errors++;
        end
        if (tracker.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
